>>> rtl/core/hkc_pkg.sv
`timescale 1ns / 1ps

package hkc_pkg;

	// Default word buffer depth
	localparam int MAX_WORD_LEN_DEF = 32;

	// Hangul syllable arithmetic
	localparam logic [15:0] HANGUL_BASE  = 16'hAC00;
	localparam int          MEDIAL_COUNT = 21;
	localparam int          FINAL_COUNT  = 28;

	// Lookahead window: initial, up to two medials, final pair, next medial
	localparam int WIN     = 6;
	localparam int TDATA_W = 24;

	typedef logic [15:0] key_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_JAMO = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	// One table match: hit flag and jamo index
	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
	} jamo_t;

	// Decision for one syllable
	typedef struct packed {
		logic       ok;
		logic [4:0] ini;
		logic [4:0] med;
		logic [4:0] fin;
		logic [2:0] adv;
	} dec_t;

	// Initial consonant keys
	function automatic jamo_t initial_idx(input key_t k);
		jamo_t r;
		r.hit = 1'b1;
		case (k)
			16'h0072: r.idx = 5'd0;  // r
			16'h0052: r.idx = 5'd1;  // R
			16'h0073: r.idx = 5'd2;  // s
			16'h0065: r.idx = 5'd3;  // e
			16'h0045: r.idx = 5'd4;  // E
			16'h0066: r.idx = 5'd5;  // f
			16'h0061: r.idx = 5'd6;  // a
			16'h0071: r.idx = 5'd7;  // q
			16'h0051: r.idx = 5'd8;  // Q
			16'h0074: r.idx = 5'd9;  // t
			16'h0054: r.idx = 5'd10; // T
			16'h0064: r.idx = 5'd11; // d
			16'h0077: r.idx = 5'd12; // w
			16'h0057: r.idx = 5'd13; // W
			16'h0063: r.idx = 5'd14; // c
			16'h007A: r.idx = 5'd15; // z
			16'h0078: r.idx = 5'd16; // x
			16'h0076: r.idx = 5'd17; // v
			16'h0067: r.idx = 5'd18; // g
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Single-key medial vowels
	function automatic jamo_t medial_single(input key_t k);
		jamo_t r;
		r.hit = 1'b1;
		case (k)
			16'h006B: r.idx = 5'd0;  // k
			16'h006F: r.idx = 5'd1;  // o
			16'h0069: r.idx = 5'd2;  // i
			16'h004F: r.idx = 5'd3;  // O
			16'h006A: r.idx = 5'd4;  // j
			16'h0070: r.idx = 5'd5;  // p
			16'h0075: r.idx = 5'd6;  // u
			16'h0050: r.idx = 5'd7;  // P
			16'h0068: r.idx = 5'd8;  // h
			16'h0079: r.idx = 5'd12; // y
			16'h006E: r.idx = 5'd13; // n
			16'h0062: r.idx = 5'd17; // b
			16'h006D: r.idx = 5'd18; // m
			16'h006C: r.idx = 5'd20; // l
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Two-key medial vowels
	function automatic jamo_t medial_pair(input key_t a, input key_t b);
		jamo_t r;
		r.hit = 1'b1;
		case ({a, b})
			32'h0068_006B: r.idx = 5'd9;  // hk
			32'h0068_006F: r.idx = 5'd10; // ho
			32'h0068_006C: r.idx = 5'd11; // hl
			32'h006E_006A: r.idx = 5'd14; // nj
			32'h006E_0070: r.idx = 5'd15; // np
			32'h006E_006C: r.idx = 5'd16; // nl
			32'h006D_006C: r.idx = 5'd19; // ml
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Single-key finals, index already offset by one
	function automatic jamo_t final_single(input key_t k);
		jamo_t r;
		r.hit = 1'b1;
		case (k)
			16'h0072: r.idx = 5'd1;  // r
			16'h0052: r.idx = 5'd2;  // R
			16'h0073: r.idx = 5'd4;  // s
			16'h0065: r.idx = 5'd7;  // e
			16'h0066: r.idx = 5'd8;  // f
			16'h0061: r.idx = 5'd16; // a
			16'h0071: r.idx = 5'd17; // q
			16'h0074: r.idx = 5'd19; // t
			16'h0054: r.idx = 5'd20; // T
			16'h0064: r.idx = 5'd21; // d
			16'h0077: r.idx = 5'd22; // w
			16'h0063: r.idx = 5'd23; // c
			16'h007A: r.idx = 5'd24; // z
			16'h0078: r.idx = 5'd25; // x
			16'h0076: r.idx = 5'd26; // v
			16'h0067: r.idx = 5'd27; // g
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Two-key finals
	function automatic jamo_t final_pair(input key_t a, input key_t b);
		jamo_t r;
		r.hit = 1'b1;
		case ({a, b})
			32'h0072_0074: r.idx = 5'd3;  // rt
			32'h0073_0077: r.idx = 5'd5;  // sw
			32'h0073_0067: r.idx = 5'd6;  // sg
			32'h0066_0072: r.idx = 5'd9;  // fr
			32'h0066_0061: r.idx = 5'd10; // fa
			32'h0066_0071: r.idx = 5'd11; // fq
			32'h0066_0074: r.idx = 5'd12; // ft
			32'h0066_0078: r.idx = 5'd13; // fx
			32'h0066_0076: r.idx = 5'd14; // fv
			32'h0066_0067: r.idx = 5'd15; // fg
			32'h0071_0074: r.idx = 5'd18; // qt
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/hkc_word_buf.sv
`timescale 1ns / 1ps

module hkc_word_buf import hkc_pkg::*; #(
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
	localparam int AW    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1,
	localparam int CNT_W = $clog2(MAX_WORD_LEN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	// write side: one transfer per key
	input  logic             wr_en,
	input  key_t             wr_key,
	input  logic             wr_last,
	// word summary, valid in the cycle of the last transfer
	output logic [CNT_W-1:0] word_len,
	output logic             word_ovf,
	// read side, registered read data
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output key_t             rd_data
);

	key_t             mem [MAX_WORD_LEN];
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	key_t             rd_data_q;
	logic             full;

	assign full     = (count_q == CNT_W'(MAX_WORD_LEN));
	assign word_len = count_q + CNT_W'(1);
	assign word_ovf = ovf_q || full;
	assign rd_data  = rd_data_q;

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (wr_en) begin
			if (wr_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem[count_q[AW-1:0]] <= wr_key;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/hkc_syl_buf.sv
`timescale 1ns / 1ps

module hkc_syl_buf import hkc_pkg::*; #(
	parameter int DEPTH = MAX_WORD_LEN_DEF / 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data_q;

	assign rd_data = rd_data_q;

	// composed syllables, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/hkc_syl_decode.sv
`timescale 1ns / 1ps

module hkc_syl_decode import hkc_pkg::*; (
	input  logic [WIN-1:0][15:0] win,  // keys at word positions p .. p+5
	input  logic [WIN-1:0]       vld,  // position lies inside the word
	output dec_t                 dec
);

	jamo_t ini, dmed, smed, dfin, sfin, med1_nxt, med2_nxt;
	logic  dm_hit, df_hit, sm_q1, sm_q2;
	key_t  fk0, fk1, mk2;
	logic  fv0, fv1, mv2;
	logic [2:0] q;

	always_comb begin
		// initial and medial
		ini    = initial_idx(win[0]);
		dmed   = medial_pair(win[1], win[2]);
		smed   = medial_single(win[1]);
		dm_hit = vld[2] && dmed.hit;

		// final region starts after the medial
		if (dm_hit) begin
			q   = 3'd3;
			fk0 = win[3];
			fk1 = win[4];
			mk2 = win[5];
			fv0 = vld[3];
			fv1 = vld[4];
			mv2 = vld[5];
		end else begin
			q   = 3'd2;
			fk0 = win[2];
			fk1 = win[3];
			mk2 = win[4];
			fv0 = vld[2];
			fv1 = vld[3];
			mv2 = vld[4];
		end

		dfin     = final_pair(fk0, fk1);
		sfin     = final_single(fk0);
		med1_nxt = medial_single(fk1);
		med2_nxt = medial_single(mk2);
		df_hit   = fv1 && dfin.hit;
		sm_q1    = fv1 && med1_nxt.hit;
		sm_q2    = mv2 && med2_nxt.hit;

		dec.ok  = ini.hit && (dm_hit || (vld[1] && smed.hit));
		dec.ini = ini.idx;
		dec.med = dm_hit ? dmed.idx : smed.idx;

		// final choice and advance to the next initial
		if (df_hit) begin
			if (sm_q2) begin
				// second key of the pair opens the next syllable
				dec.fin = sfin.idx;
				dec.adv = q + 3'd1;
			end else begin
				dec.fin = dfin.idx;
				dec.adv = q + 3'd2;
			end
		end else if (sm_q1) begin
			// consonant moves on as the next initial
			dec.fin = 5'd0;
			dec.adv = q;
		end else begin
			// single final, or a key that is no final is skipped
			dec.fin = (fv0 && sfin.hit) ? sfin.idx : 5'd0;
			dec.adv = q + 3'd1;
		end
	end

endmodule

>>> rtl/core/keystroke_to_hangul_composer_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[15:0] key_unit, s_tlast end_of_word
// m_*      out  m_tvalid/m_tready  m_tdata[15:0] syllable, [17:16] status, m_tlast last_of_word
//
// A key that does not end its word is only written to the word store.
// At the end of a word the composer walks the word store: per syllable it fetches
// the keys it lacks (the full six-key window for the first), evaluates and commits
// (adv = keys consumed, 2..5), then reads each result out of the syllable store.
// Keys are taken only between words; the last result may wait in the output
// register while the next word is typed. Reset clears the control state only.

module keystroke_to_hangul_composer_core import hkc_pkg::*; #(
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // [15:0] key_unit
	input  logic               s_tlast,   // end_of_word
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [15:0] syllable, [17:16] status, rest zero
	output logic               m_tlast    // last_of_word
);

	localparam int SYL_DEPTH = MAX_WORD_LEN / 2;
	localparam int AW    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int SAW   = (SYL_DEPTH > 1) ? $clog2(SYL_DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);
	localparam int SCW   = $clog2(SYL_DEPTH + 1);
	localparam int POS_W = $clog2(MAX_WORD_LEN + 8);

	typedef enum logic [6:0] {
		S_COLLECT = 7'b0000001,
		S_FETCH   = 7'b0000010,
		S_EVAL    = 7'b0000100,
		S_COMMIT  = 7'b0001000,
		S_READ    = 7'b0010000,
		S_LOAD    = 7'b0100000,
		S_ERR     = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    n_q;
	logic [POS_W-1:0]    p_q, p_nxt;
	logic [2:0]          iss_q, got_q;
	logic                rd_pend_s1;
	logic [2:0]          rd_slot_s1;
	logic [WIN-1:0][15:0] win_q;
	logic [WIN-1:0]      vld;
	dec_t                dec, dec_s1;
	logic [SCW-1:0]      ns_q, ek_q;
	status_t             err_q;

	logic                in_xfer;
	logic [CNT_W-1:0]    word_len;
	logic                word_ovf;
	logic                wrd_rd_en;
	logic [AW-1:0]       wrd_rd_addr;
	key_t                wrd_rd_data;

	logic                syl_wr_en;
	logic [15:0]         syl_code;
	logic                syl_rd_en;
	logic [15:0]         syl_rd_data;

	logic                out_valid_q, out_last_q;
	logic [15:0]         out_syl_q;
	status_t             out_st_q;
	logic                out_free, out_load, emit_last;

	assign s_tready = (state_q == S_COLLECT);
	assign in_xfer  = s_tvalid && s_tready;

	hkc_word_buf #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_word_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_xfer),
		.wr_key   (s_tdata),
		.wr_last  (s_tlast),
		.word_len (word_len),
		.word_ovf (word_ovf),
		.rd_en    (wrd_rd_en),
		.rd_addr  (wrd_rd_addr),
		.rd_data  (wrd_rd_data)
	);

	// window fetch address
	assign wrd_rd_en   = (state_q == S_FETCH) && (iss_q != 3'(WIN));
	assign wrd_rd_addr = AW'(p_q + POS_W'(iss_q));

	// window positions inside the word
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			vld[k] = (p_q + POS_W'(k)) < POS_W'(n_q);
		end
	end

	hkc_syl_decode u_decode (
		.win (win_q),
		.vld (vld),
		.dec (dec)
	);

	// syllable code and store
	assign syl_code = HANGUL_BASE
		+ 16'(dec_s1.ini) * 16'(MEDIAL_COUNT * FINAL_COUNT)
		+ 16'(dec_s1.med) * 16'(FINAL_COUNT)
		+ 16'(dec_s1.fin);
	assign syl_wr_en = (state_q == S_COMMIT) && dec_s1.ok;
	assign syl_rd_en = (state_q == S_READ);
	assign p_nxt     = p_q + POS_W'(dec_s1.adv);

	hkc_syl_buf #(.DEPTH(SYL_DEPTH)) u_syl_buf (
		.clk     (clk),
		.wr_en   (syl_wr_en),
		.wr_addr (ns_q[SAW-1:0]),
		.wr_data (syl_code),
		.rd_en   (syl_rd_en),
		.rd_addr (ek_q[SAW-1:0]),
		.rd_data (syl_rd_data)
	);

	// output register handoff
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = out_free && ((state_q == S_LOAD) || (state_q == S_ERR));
	assign emit_last = ((ek_q + SCW'(1)) == ns_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			n_q         <= '0;
			p_q         <= '0;
			iss_q       <= '0;
			got_q       <= '0;
			rd_pend_s1  <= 1'b0;
			ns_q        <= '0;
			ek_q        <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= wrd_rd_en;
			if (rd_pend_s1) begin
				got_q <= got_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_COLLECT: begin
					if (in_xfer && s_tlast) begin
						n_q <= word_len;
						if (word_ovf) begin
							err_q   <= ST_TOO_LONG;
							state_q <= S_ERR;
						end else begin
							p_q     <= '0;
							ns_q    <= '0;
							iss_q   <= '0;
							got_q   <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					if (iss_q != 3'(WIN)) begin
						iss_q <= iss_q + 3'd1;
					end else if (got_q == 3'(WIN)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (!dec_s1.ok) begin
						err_q   <= ST_BAD_JAMO;
						state_q <= S_ERR;
					end else begin
						ns_q  <= ns_q + SCW'(1);
						p_q   <= p_nxt;
						got_q <= 3'(WIN) - dec_s1.adv;
						iss_q <= 3'(WIN) - dec_s1.adv;
						if (p_nxt >= POS_W'(n_q)) begin
							ek_q    <= '0;
							state_q <= S_READ;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_load) begin
						if (emit_last) begin
							state_q <= S_COLLECT;
						end else begin
							ek_q    <= ek_q + SCW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_ERR: begin
					if (out_load) begin
						state_q <= S_COLLECT;
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	// window, decision and output payload
	always_ff @(posedge clk) begin
		if (wrd_rd_en) begin
			rd_slot_s1 <= iss_q;
		end
		if (rd_pend_s1) begin
			win_q[rd_slot_s1] <= wrd_rd_data;
		end else if (state_q == S_COMMIT) begin
			for (int k = 0; k < WIN; k++) begin
				if ((k + int'(dec_s1.adv)) < WIN) begin
					win_q[k] <= win_q[3'(k + int'(dec_s1.adv))];
				end
			end
		end
		if (state_q == S_EVAL) begin
			dec_s1 <= dec;
		end
		if (out_load) begin
			if (state_q == S_LOAD) begin
				out_syl_q  <= syl_rd_data;
				out_st_q   <= ST_OK;
				out_last_q <= emit_last;
			end else begin
				out_syl_q  <= 16'd0;
				out_st_q   <= err_q;
				out_last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(TDATA_W - 18)'(0), out_st_q, out_syl_q};
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/core/hkc_checker.sv
`timescale 1ns / 1ps

module hkc_checker import hkc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	// stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// stalled result holds its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// error result is alone, closes the word and carries no syllable
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[17:16] != ST_OK) |-> m_tlast && (m_tdata[15:0] == 16'd0))
		else $error("malformed error result");

	// good result lies in the syllable block
	a_syl_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[17:16] == ST_OK) |->
			(m_tdata[15:0] >= 16'hAC00) && (m_tdata[15:0] <= 16'hD7A3))
		else $error("syllable out of range");

	// padding is zero and status code is defined
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TDATA_W-1:18] == '0) && (m_tdata[17:16] != 2'd3))
		else $error("bad padding or status");

endmodule

bind keystroke_to_hangul_composer_core hkc_checker u_hkc_checker (.*);

>>> bench/tb_keystroke_to_hangul_composer_core.sv
`timescale 1ns / 1ps

module tb_keystroke_to_hangul_composer_core;
	import hkc_pkg::*;

	localparam int WORD_DEPTH = MAX_WORD_LEN_DEF;
	localparam int SYL_DEPTH  = WORD_DEPTH / 2;
	localparam int RAND_ITEMS = 480;
	localparam int HOLD_LEN   = 300;
	localparam int DRAIN_WAIT = 50;
	localparam int CYCLE_LIMIT = 200000;

	// Jamo key tables, one ASCII char per entry, '.' = no second key
	localparam logic [8*27-1:0] INI_KEYS = "rRseEfaqQtTdwWczxvg";
	localparam logic [8*27-1:0] MED_A    = "koiOjpuPhhhhynnnnbmml";
	localparam logic [8*27-1:0] MED_B    = ".........kol..jpl..l.";
	localparam logic [8*27-1:0] FIN_A    = "rRrssseffffffffaqqtTdwczxvg";
	localparam logic [8*27-1:0] FIN_B    = "..t.wg..raqtxvg..t.........";

	typedef struct packed {
		logic [15:0] syl;
		status_t     st;
		logic        last;
	} syl_res_t;

	typedef struct {
		logic [15:0] key;
		bit          eow;
		bit          typed;
		logic [15:0] syl;
		status_t     st;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [15:0]        s_tdata;   // [15:0] key_unit
	logic               s_tlast;   // end_of_word
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // [15:0] syllable, [17:16] status, rest zero
	logic               m_tlast;   // last_of_word

	// Predictor state
	logic [15:0] word_buf [WORD_DEPTH];
	logic [15:0] syl_buf [SYL_DEPTH];
	int          unit_cnt;
	bit          word_overflow;
	syl_res_t    syl_expect_q[$];

	dir_row_t    dir_tbl[$];
	logic [15:0] word_keys[$];

	int src_idle_pct;
	int snk_idle_pct;
	int hold_asked;
	int hold_taken;
	int hold_left;
	int bad_count;
	int cycle_count;

	keystroke_to_hangul_composer_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Table lookup: entry j of a char table with len entries
	function automatic logic [15:0] tbl_key(input logic [8*27-1:0] tbl, input int len,
			input int j);
		logic [7:0] c;
		c = tbl[8*(len-1-j) +: 8];
		return (c == ".") ? 16'h0000 : {8'h00, c};
	endfunction

	function automatic int initial_val(input logic [15:0] k);
		for (int j = 0; j < 19; j++) begin
			if (k != 0 && k == tbl_key(INI_KEYS, 19, j))
				return j * 21 * 28;
		end
		return -1;
	endfunction

	function automatic int medial_val(input logic [15:0] a, input logic [15:0] b);
		if (a == 0)
			return -1;
		for (int j = 0; j < 21; j++) begin
			if (a == tbl_key(MED_A, 21, j) && b == tbl_key(MED_B, 21, j))
				return j * 28;
		end
		return -1;
	endfunction

	function automatic int final_val(input logic [15:0] a, input logic [15:0] b);
		if (a == 0)
			return -1;
		for (int j = 0; j < 27; j++) begin
			if (a == tbl_key(FIN_A, 27, j) && b == tbl_key(FIN_B, 27, j))
				return j + 1;
		end
		return -1;
	endfunction

	// Window reads on the stored word, -1 past the end or on no match
	function automatic int med_one(input int i, input int n);
		if (i < 0 || i + 1 > n)
			return -1;
		return medial_val(word_buf[i], 16'h0000);
	endfunction

	function automatic int med_two(input int i, input int n);
		if (i < 0 || i + 2 > n || word_buf[i+1] == 0)
			return -1;
		return medial_val(word_buf[i], word_buf[i+1]);
	endfunction

	function automatic int fin_one(input int i, input int n);
		if (i < 0 || i + 1 > n)
			return -1;
		return final_val(word_buf[i], 16'h0000);
	endfunction

	function automatic int fin_two(input int i, input int n);
		if (i < 0 || i + 2 > n || word_buf[i+1] == 0)
			return -1;
		return final_val(word_buf[i], word_buf[i+1]);
	endfunction

	// Walk the stored word; syllable count, or -1 on a bad initial or medial
	function automatic int compose_syllables(input int n);
		int cnt;
		int i;
		int ini;
		int med;
		int fin;
		int t;
		cnt = 0;
		i = 0;
		while (i < n) begin
			ini = initial_val(word_buf[i]);
			i++;
			t = med_two(i, n);
			if (t != -1) begin
				med = t;
				i += 2;
			end else begin
				med = med_one(i, n);
				i++;
			end
			t = fin_two(i, n);
			if (t != -1) begin
				// Split the pair when a vowel follows its second key
				fin = t;
				if (med_one(i + 2, n) != -1)
					fin = fin_one(i, n);
				else
					i++;
			end else if (med_one(i + 1, n) != -1) begin
				// Consonant moves on as the next initial
				fin = 0;
				i--;
			end else begin
				fin = fin_one(i, n);
				if (fin == -1)
					fin = 0;
			end
			if (ini == -1 || med == -1)
				return -1;
			if (cnt < SYL_DEPTH) begin
				syl_buf[cnt] = 16'hAC00 + 16'(ini + med + fin);
				cnt++;
			end
			i++;
		end
		return cnt;
	endfunction

	// Store one accepted key; at end of word queue the expected results
	task automatic store_key(input logic [15:0] key, input bit eow, input bit push_exp);
		int n;
		syl_res_t r;
		if (unit_cnt < WORD_DEPTH) begin
			word_buf[unit_cnt] = key;
			unit_cnt++;
		end else begin
			word_overflow = 1'b1;
		end
		if (eow) begin
			r.syl = 16'h0000;
			r.last = 1'b1;
			if (word_overflow) begin
				r.st = ST_TOO_LONG;
				if (push_exp)
					syl_expect_q.push_back(r);
			end else begin
				n = compose_syllables(unit_cnt);
				if (n < 0) begin
					r.st = ST_BAD_JAMO;
					if (push_exp)
						syl_expect_q.push_back(r);
				end else if (push_exp) begin
					for (int k = 0; k < n; k++) begin
						r.syl = syl_buf[k];
						r.st = ST_OK;
						r.last = (k == n - 1);
						syl_expect_q.push_back(r);
					end
				end
			end
			unit_cnt = 0;
			word_overflow = 1'b0;
		end
	endtask

	// Offer one key, with random idle cycles first; returns at its transfer
	task automatic send_key(input logic [15:0] key, input bit eow);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= key;
		s_tlast <= eow;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (syl_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(input logic [15:0] key, input bit eow, input bit typed,
			input logic [15:0] syl, input status_t st);
		dir_row_t row;
		row.key = key;
		row.eow = eow;
		row.typed = typed;
		row.syl = syl;
		row.st = st;
		dir_tbl.push_back(row);
	endtask

	function automatic logic [15:0] rand_letter();
		return {8'h00, ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25))};
	endfunction

	// Random word into word_keys: mostly well-formed syllables, some noise
	task automatic build_word();
		int kind;
		int nsyl;
		int j;
		int pos;
		logic [15:0] b;
		word_keys.delete();
		kind = $urandom_range(99);
		if (kind < 3) begin
			// Too long for the store
			nsyl = $urandom_range(WORD_DEPTH + 8, WORD_DEPTH + 1);
			for (int k = 0; k < nsyl; k++)
				word_keys.push_back(rand_letter());
		end else if (kind < 5) begin
			// Fills the store exactly: most results per word
			for (int k = 0; k < SYL_DEPTH; k++) begin
				word_keys.push_back(tbl_key(INI_KEYS, 19, $urandom_range(18)));
				word_keys.push_back(tbl_key(MED_A, 21, $urandom_range(20)));
			end
		end else begin
			nsyl = $urandom_range(5, 1);
			for (int k = 0; k < nsyl; k++) begin
				word_keys.push_back(tbl_key(INI_KEYS, 19, $urandom_range(18)));
				j = $urandom_range(20);
				word_keys.push_back(tbl_key(MED_A, 21, j));
				b = tbl_key(MED_B, 21, j);
				if (b != 0)
					word_keys.push_back(b);
				if ($urandom_range(99) >= 35) begin
					j = $urandom_range(26);
					word_keys.push_back(tbl_key(FIN_A, 27, j));
					b = tbl_key(FIN_B, 27, j);
					if (b != 0)
						word_keys.push_back(b);
				end
			end
			// Broken words: corrupted keys or a cut-off tail
			if (kind < 20) begin
				for (int k = 0; k < $urandom_range(2, 1); k++) begin
					pos = $urandom_range(word_keys.size() - 1);
					case ($urandom_range(3))
						0: word_keys[pos] = 16'($urandom);
						1: word_keys[pos] = 16'h0000;
						2: word_keys[pos] = rand_letter();
						default: begin
							if (word_keys.size() > 1)
								void'(word_keys.pop_back());
						end
					endcase
				end
			end
		end
	endtask

	// Result side: check each transfer, random or held-off ready
	always @(posedge clk) begin : sink_side
		syl_res_t got;
		syl_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.syl = m_tdata[15:0];
				got.st = status_t'(m_tdata[17:16]);
				got.last = m_tlast;
				if (syl_expect_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected result: syl=%h st=%0d last=%0b",
							got.syl, got.st, got.last);
				end else begin
					want = syl_expect_q.pop_front();
					if (got.syl !== want.syl || got.st !== want.st || got.last !== want.last) begin
						bad_count++;
						if (bad_count <= 10)
							$display("mismatch: expected syl=%h st=%0d last=%0b, got syl=%h st=%0d last=%0b",
								want.syl, want.st, want.last, got.syl, got.st, got.last);
					end
				end
			end
			if (hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// Stimulus
	initial begin
		int rand_sent;
		int phase;
		s_tvalid = 1'b0;
		s_tdata = 16'h0000;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		unit_cnt = 0;
		word_overflow = 1'b0;
		hold_asked = 0;
		hold_taken = 0;
		hold_left = 0;
		bad_count = 0;
		src_idle_pct = 20;
		snk_idle_pct = 49;
		rand_sent = 0;
		phase = 1;

		// First syllable, last syllable, bad initial, missing medial,
		// zero unit as medial, non-final key skipped, lookahead cases
		add_row("r", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("k", 1'b1, 1'b1, 16'hAC00, ST_OK);
		add_row("g", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("l", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("g", 1'b1, 1'b1, 16'hD7A3, ST_OK);
		add_row("k", 1'b1, 1'b1, 16'h0000, ST_BAD_JAMO);
		add_row("r", 1'b1, 1'b1, 16'h0000, ST_BAD_JAMO);
		add_row("r", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row(16'h0000, 1'b1, 1'b1, 16'h0000, ST_BAD_JAMO);
		add_row("r", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("k", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row(16'hFFFF, 1'b1, 1'b1, 16'hAC00, ST_OK);
		add_row("d", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("h", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("k", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("f", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("r", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("k", 1'b1, 1'b0, 16'h0000, ST_OK);
		add_row("t", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("k", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("f", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("k", 1'b0, 1'b0, 16'h0000, ST_OK);
		add_row("d", 1'b1, 1'b0, 16'h0000, ST_OK);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		foreach (dir_tbl[r]) begin
			send_key(dir_tbl[r].key, dir_tbl[r].eow);
			store_key(dir_tbl[r].key, dir_tbl[r].eow, !dir_tbl[r].typed);
			if (dir_tbl[r].typed)
				syl_expect_q.push_back('{dir_tbl[r].syl, dir_tbl[r].st, 1'b1});
		end
		wait_drained();

		// Random words in three idling phases
		while (rand_sent < RAND_ITEMS) begin
			if (phase == 1 && rand_sent >= RAND_ITEMS / 3) begin
				wait_drained();
				phase = 2;
				src_idle_pct = 49;
				snk_idle_pct = 20;
				// Long receiver stall while the sender keeps going
				hold_asked++;
			end else if (phase == 2 && rand_sent >= 2 * RAND_ITEMS / 3) begin
				wait_drained();
				phase = 3;
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			build_word();
			foreach (word_keys[k]) begin
				send_key(word_keys[k], k == word_keys.size() - 1);
				store_key(word_keys[k], k == word_keys.size() - 1, 1'b1);
				rand_sent++;
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (bad_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
